// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  // Operation codes carried in the input tuser bit
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Fixed field widths of the stream payload
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TAGF_W  = 16;
  localparam int unsigned COUNT_W = 7;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // shift the upper part up and drop the new entry in
    logic rem;  // shift the whole row down by one
  } cell_cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
// One storage cell of the sorted row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned KW    = 8,
  parameter int unsigned TW    = 16,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [KW-1:0]    new_key_i,
  input  logic [TW-1:0]    new_tag_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic             below_lt_i,
  input  logic [KW-1:0]    below_key_i,
  input  logic [TW-1:0]    below_tag_i,
  input  logic [KW-1:0]    above_key_i,
  input  logic [TW-1:0]    above_tag_i,
  output logic             lt_o,
  output logic [KW-1:0]    key_o,
  output logic [TW-1:0]    tag_o
);

  logic [KW-1:0] key_q, key_d;
  logic [TW-1:0] tag_q, tag_d;
  logic          occupied;

  // Cells below the fill level hold live entries
  assign occupied = count_i > CNT_W'(IDX);
  assign lt_o     = occupied && (key_q < new_key_i);

  // Pick hold, shift from a neighbor, or load the new entry
  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (cmd_i.rem) begin
      key_d = above_key_i;
      tag_d = above_tag_i;
    end else if (cmd_i.ins && !lt_o) begin
      if (below_lt_i) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end else begin
        key_d = below_key_i;
        tag_d = below_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: stream ports, fill counter and the cell row.
`timescale 1ns / 1ps
// Bounded priority queue built as a row of CAPACITY cells kept sorted with the
// smallest key in cell 0. An insert compares its key against every cell at once;
// cells with a smaller key hold, the rest shift up one place and the new entry
// drops into the gap, so it lands ahead of all entries of equal or greater key.
// A remove shifts the whole row down and returns what left cell 0, which is the
// smallest key and, among equal keys, the most recently inserted entry. Every
// transaction yields one result; a new transaction is taken in every cycle in
// which the output register is empty or being drained.
// Inserts into a full queue and removes from an empty one leave it unchanged
// and report their status with zero key and tag.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 8,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] priority_req, [23:8] tag
  input  logic [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_priority, [23:8] out_tag, [30:24] count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned KW    = (KEY_BITS < PRIO_W) ? KEY_BITS : PRIO_W;
  localparam int unsigned TW    = (TAG_BITS < TAGF_W) ? TAG_BITS : TAGF_W;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             in_fire;
  logic             is_remove;
  logic             full;
  logic             empty;
  logic [KW-1:0]    new_key;
  logic [TW-1:0]    new_tag;
  cell_cmd_t        cmd;
  logic [CNT_W-1:0] count_q, count_d;

  logic [CAPACITY-1:0] lt;
  logic [KW-1:0]       cell_key [CAPACITY];
  logic [TW-1:0]       cell_tag [CAPACITY];

  logic              out_valid_q;
  logic [1:0]        status_q, status_d;
  logic [PRIO_W-1:0] out_prio_q, out_prio_d;
  logic [TAGF_W-1:0] out_tag_q, out_tag_d;

  // Accept when the output register is free or emptying this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_remove     = (s_axis_tuser[0] == OP_REMOVE);
  assign full          = (count_q == CNT_W'(CAPACITY));
  assign empty         = (count_q == '0);
  assign new_key       = s_axis_tdata[KW-1:0];
  assign new_tag       = s_axis_tdata[PRIO_W +: TW];

  assign cmd.ins = in_fire && !is_remove && !full;
  assign cmd.rem = in_fire && is_remove && !empty;

  // Build the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          below_lt;
    logic [KW-1:0] below_key, above_key;
    logic [TW-1:0] below_tag, above_tag;

    if (i == 0) begin : g_first
      assign below_lt  = 1'b1;
      assign below_key = '0;
      assign below_tag = '0;
    end else begin : g_mid_lo
      assign below_lt  = lt[i-1];
      assign below_key = cell_key[i-1];
      assign below_tag = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above_key = '0;
      assign above_tag = '0;
    end else begin : g_mid_hi
      assign above_key = cell_key[i+1];
      assign above_tag = cell_tag[i+1];
    end

    spq_cell #(
      .KW    (KW),
      .TW    (TW),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .new_key_i   (new_key),
      .new_tag_i   (new_tag),
      .count_i     (count_q),
      .below_lt_i  (below_lt),
      .below_key_i (below_key),
      .below_tag_i (below_tag),
      .above_key_i (above_key),
      .above_tag_i (above_tag),
      .lt_o        (lt[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  // Track fill level and form the result
  always_comb begin
    count_d    = count_q;
    status_d   = ST_DONE;
    out_prio_d = '0;
    out_tag_d  = '0;
    if (is_remove) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d    = count_q - CNT_W'(1);
        out_prio_d = PRIO_W'(cell_key[0]);
        out_tag_d  = TAGF_W'(cell_tag[0]);
      end
    end else begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Hold control state and the output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload
  logic [CNT_W-1:0] out_count_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q    <= status_d;
      out_prio_q  <= out_prio_d;
      out_tag_q   <= out_tag_d;
      out_count_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {1'b0, COUNT_W'(out_count_q), out_tag_q, out_prio_q};

endmodule
